@@ sv/csvft_pkg.sv @@
// Shared types and constants of the CSV field tokenizer.
`timescale 1ns / 1ps

package csvft_pkg;

	localparam logic [1:0] EV_BYTE  = 2'd0;
	localparam logic [1:0] EV_FIELD = 2'd1;
	localparam logic [1:0] EV_REC   = 2'd2;
	localparam logic [1:0] EV_ERR   = 2'd3;

	localparam logic [2:0] ERR_NONE     = 3'd0;
	localparam logic [2:0] ERR_DELIM    = 3'd1;
	localparam logic [2:0] ERR_AFTER_Q  = 3'd2;
	localparam logic [2:0] ERR_MISPLACE = 3'd3;
	localparam logic [2:0] ERR_EOF_Q    = 3'd4;

	localparam logic [1:0] CFG_DELIM = 2'd0;
	localparam logic [1:0] CFG_TRIM  = 2'd1;
	localparam logic [1:0] CFG_SKIP  = 2'd2;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SPACE = 8'h20;

	typedef struct packed {
		logic [1:0]  ev;
		logic [7:0]  data;
		logic        quoted;
		logic [31:0] line;
		logic [15:0] col;
		logic [2:0]  err;
	} event_t;

	typedef struct packed {
		logic flush_one;
		logic flush_all;
		logic has_final;
		logic held_empty;
		logic held_last;
		logic plan_one;
		logic out_free;
	} status_t;

	typedef struct packed {
		logic apply;
		logic pop;
		logic load_now;
		logic load_saved;
	} cmd_t;

endpackage

@@ sv/csvft_ctrl.sv @@
// Controller state machine that sequences the transfers of one input byte.
`timescale 1ns / 1ps

module csvft_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  csvft_pkg::status_t  st,
	output csvft_pkg::cmd_t     cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_FLUSH,
		S_FINAL
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (st.flush_one || (st.flush_all && !st.held_empty)) begin
							state_q <= S_FLUSH;
						end else if (st.has_final && !st.out_free) begin
							state_q <= S_FINAL;
						end
					end
				end
				S_FLUSH: begin
					if (st.out_free) begin
						if (st.plan_one) begin
							state_q <= S_IDLE;
						end else if (st.held_last) begin
							state_q <= S_FINAL;
						end
					end
				end
				S_FINAL: begin
					if (st.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		in_ready       = (state_q == S_IDLE);
		cmd            = '0;
		cmd.apply      = (state_q == S_IDLE) && in_valid;
		cmd.load_now   = cmd.apply && !st.flush_one
			&& !(st.flush_all && !st.held_empty) && st.has_final && st.out_free;
		cmd.pop        = (state_q == S_FLUSH) && st.out_free;
		cmd.load_saved = (state_q == S_FINAL) && st.out_free;
	end

endmodule

@@ sv/csvft_dp.sv @@
// Datapath: parser state, blank hold register, counters, settings and result register.
`timescale 1ns / 1ps

module csvft_dp #(
	parameter int BLANK_HOLD = 16,
	parameter int LINE_BITS  = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [1:0]          cfg_index,
	input  logic [7:0]          cfg_wdata,
	input  logic                in_kind,
	input  logic [7:0]          in_byte,
	input  csvft_pkg::cmd_t     cmd,
	output csvft_pkg::status_t  st,
	output logic                out_valid,
	input  logic                out_ready,
	output csvft_pkg::event_t   out_ev,
	output logic                out_last
);

	localparam int CNT_W  = $clog2(BLANK_HOLD + 1);
	localparam int HIDX_W = (BLANK_HOLD > 1) ? $clog2(BLANK_HOLD) : 1;

	typedef enum logic [1:0] {
		MODE_FIELD,
		MODE_INQ,
		MODE_QPEND,
		MODE_AFTERQ
	} mode_t;

	typedef struct packed {
		logic quoted;
		logic raw;
		logic emitted;
	} flags_t;

	logic [7:0]            delim_q;
	logic                  trim_q;
	logic                  skip_q;

	mode_t                 mode_q, nx_mode;
	logic                  acr_q, nx_acr;
	logic [BLANK_HOLD-1:0] held_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [LINE_BITS-1:0]  phys_q, nx_phys;
	logic [LINE_BITS-1:0]  rec_q, nx_rec;
	logic [15:0]           fidx_q, nx_fidx;
	flags_t                flags_q, nx_flags;
	logic                  halted_q, nx_halted;

	logic                  plan_one_q;
	logic                  plan_tab_q;
	csvft_pkg::event_t     fin_q;

	logic                  hold_clear, hold_append, is_tab;
	logic                  flush_one, flush_all, fin_valid;
	csvft_pkg::event_t     fin;
	csvft_pkg::event_t     pop_ev;
	logic                  bad, is_nl, is_blank, do_fld, do_rec, do_restart;
	logic [LINE_BITS-1:0]  phys_inc;
	logic [15:0]           col_err;
	logic [BLANK_HOLD-1:0] held_shift;

	function automatic logic [31:0] sat_line(input logic [LINE_BITS-1:0] v);
		logic [63:0] w;
		w = 64'(v);
		sat_line = (w > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : w[31:0];
	endfunction

	always_comb begin
		bad = (delim_q == csvft_pkg::CH_NUL) || (delim_q == csvft_pkg::CH_QUOTE)
			|| (delim_q == csvft_pkg::CH_CR) || (delim_q == csvft_pkg::CH_LF);
		is_nl    = (in_byte == csvft_pkg::CH_CR) || (in_byte == csvft_pkg::CH_LF);
		is_tab   = (in_byte == csvft_pkg::CH_TAB);
		is_blank = is_tab || (in_byte == csvft_pkg::CH_SPACE);
		phys_inc = (phys_q == '1) ? phys_q : phys_q + LINE_BITS'(1);
		col_err  = (fidx_q == 16'hFFFF) ? 16'hFFFF : fidx_q + 16'd1;

		nx_mode     = mode_q;
		nx_acr      = acr_q;
		nx_phys     = phys_q;
		nx_rec      = rec_q;
		nx_fidx     = fidx_q;
		nx_flags    = flags_q;
		nx_halted   = halted_q;
		hold_clear  = 1'b0;
		hold_append = 1'b0;
		flush_one   = 1'b0;
		flush_all   = 1'b0;
		fin_valid   = 1'b0;
		do_fld      = 1'b0;
		do_rec      = 1'b0;
		do_restart  = 1'b0;
		fin         = '0;
		fin.ev      = csvft_pkg::EV_BYTE;
		fin.line    = sat_line(rec_q);
		fin.err     = csvft_pkg::ERR_NONE;

		if (halted_q) begin
			do_restart = in_kind;
		end else if (bad) begin
			fin_valid = 1'b1;
			fin.ev    = csvft_pkg::EV_ERR;
			fin.line  = '0;
			fin.err   = csvft_pkg::ERR_DELIM;
			if (in_kind) begin
				do_restart = 1'b1;
			end else begin
				nx_halted = 1'b1;
			end
		end else if (in_kind) begin
			if (mode_q == MODE_INQ) begin
				fin_valid = 1'b1;
				fin.ev    = csvft_pkg::EV_ERR;
				fin.col   = col_err;
				fin.err   = csvft_pkg::ERR_EOF_Q;
			end else if (mode_q != MODE_FIELD || fidx_q != 16'd0 || flags_q.raw) begin
				do_rec = 1'b1;
			end
			do_restart = 1'b1;
		end else begin
			nx_acr = 1'b0;
			if (acr_q && in_byte == csvft_pkg::CH_LF) begin
				// The LF of a CRLF pair has already been counted.
			end else if (mode_q == MODE_INQ) begin
				if (in_byte == csvft_pkg::CH_QUOTE) begin
					nx_mode = MODE_QPEND;
				end else if (is_nl) begin
					fin_valid = 1'b1;
					fin.data  = csvft_pkg::CH_LF;
					nx_phys   = phys_inc;
					nx_acr    = (in_byte == csvft_pkg::CH_CR);
				end else begin
					fin_valid = 1'b1;
					fin.data  = in_byte;
				end
			end else if (mode_q == MODE_QPEND && in_byte == csvft_pkg::CH_QUOTE) begin
				fin_valid = 1'b1;
				fin.data  = csvft_pkg::CH_QUOTE;
				nx_mode   = MODE_INQ;
			end else if (mode_q == MODE_QPEND || mode_q == MODE_AFTERQ) begin
				nx_mode = MODE_AFTERQ;
				if (in_byte == delim_q) begin
					do_fld = 1'b1;
				end else if (is_blank) begin
					// Blanks after a closing quote are dropped.
				end else if (is_nl) begin
					do_rec  = 1'b1;
					nx_phys = phys_inc;
					nx_rec  = phys_inc;
					nx_acr  = (in_byte == csvft_pkg::CH_CR);
				end else begin
					fin_valid = 1'b1;
					fin.ev    = csvft_pkg::EV_ERR;
					fin.line  = sat_line(phys_q);
					fin.col   = col_err;
					fin.err   = csvft_pkg::ERR_AFTER_Q;
					nx_halted = 1'b1;
				end
			end else begin
				if (in_byte == delim_q) begin
					do_fld = 1'b1;
				end else if (is_nl) begin
					do_rec  = 1'b1;
					nx_phys = phys_inc;
					nx_rec  = phys_inc;
					nx_acr  = (in_byte == csvft_pkg::CH_CR);
				end else if (in_byte == csvft_pkg::CH_QUOTE) begin
					if (flags_q.emitted) begin
						fin_valid = 1'b1;
						fin.ev    = csvft_pkg::EV_ERR;
						fin.line  = sat_line(phys_q);
						fin.col   = col_err;
						fin.err   = csvft_pkg::ERR_MISPLACE;
						nx_halted = 1'b1;
					end else begin
						hold_clear = 1'b1;
						nx_flags   = '{quoted: 1'b1, raw: 1'b0, emitted: 1'b0};
						nx_mode    = MODE_INQ;
					end
				end else begin
					nx_flags.raw = 1'b1;
					if (is_blank && trim_q) begin
						if (flags_q.emitted) begin
							if (cnt_q == CNT_W'(BLANK_HOLD)) begin
								flush_one = 1'b1;
							end else begin
								hold_append = 1'b1;
							end
						end
					end else begin
						flush_all        = 1'b1;
						fin_valid        = 1'b1;
						fin.data         = in_byte;
						nx_flags.emitted = 1'b1;
					end
				end
			end
		end

		if (do_fld) begin
			fin_valid  = 1'b1;
			fin.ev     = csvft_pkg::EV_FIELD;
			fin.quoted = flags_q.quoted;
			hold_clear = 1'b1;
			nx_flags   = '0;
			nx_mode    = MODE_FIELD;
			nx_fidx    = (fidx_q == 16'hFFFF) ? fidx_q : fidx_q + 16'd1;
		end
		if (do_rec) begin
			fin_valid  = !(skip_q && fidx_q == 16'd0 && !flags_q.quoted && !flags_q.emitted);
			fin.ev     = csvft_pkg::EV_REC;
			fin.quoted = flags_q.quoted;
			hold_clear = 1'b1;
			nx_flags   = '0;
			nx_mode    = MODE_FIELD;
			nx_fidx    = '0;
		end
		if (do_restart) begin
			hold_clear = 1'b1;
			nx_mode    = MODE_FIELD;
			nx_acr     = 1'b0;
			nx_phys    = LINE_BITS'(1);
			nx_rec     = LINE_BITS'(1);
			nx_fidx    = '0;
			nx_flags   = '0;
			nx_halted  = 1'b0;
		end
	end

	always_comb begin
		held_shift = held_q >> 1;
		if (plan_one_q) begin
			held_shift[BLANK_HOLD-1] = plan_tab_q;
		end
		pop_ev      = '0;
		pop_ev.ev   = csvft_pkg::EV_BYTE;
		pop_ev.data = held_q[0] ? csvft_pkg::CH_TAB : csvft_pkg::CH_SPACE;
		pop_ev.line = sat_line(rec_q);
		pop_ev.err  = csvft_pkg::ERR_NONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delim_q <= 8'd44;
			trim_q  <= 1'b1;
			skip_q  <= 1'b1;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				csvft_pkg::CFG_DELIM: delim_q <= cfg_wdata;
				csvft_pkg::CFG_TRIM:  trim_q  <= cfg_wdata[0];
				csvft_pkg::CFG_SKIP:  skip_q  <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_FIELD;
			acr_q      <= 1'b0;
			phys_q     <= LINE_BITS'(1);
			rec_q      <= LINE_BITS'(1);
			fidx_q     <= '0;
			flags_q    <= '0;
			halted_q   <= 1'b0;
			held_q     <= '0;
			cnt_q      <= '0;
			plan_one_q <= 1'b0;
			plan_tab_q <= 1'b0;
		end else if (cmd.apply) begin
			mode_q     <= nx_mode;
			acr_q      <= nx_acr;
			phys_q     <= nx_phys;
			rec_q      <= nx_rec;
			fidx_q     <= nx_fidx;
			flags_q    <= nx_flags;
			halted_q   <= nx_halted;
			plan_one_q <= flush_one;
			plan_tab_q <= is_tab;
			if (hold_clear) begin
				held_q <= '0;
				cnt_q  <= '0;
			end else if (hold_append) begin
				held_q[cnt_q[HIDX_W-1:0]] <= is_tab;
				cnt_q                     <= cnt_q + CNT_W'(1);
			end
		end else if (cmd.pop) begin
			held_q <= held_shift;
			if (!plan_one_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.apply) begin
			fin_q <= fin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.load_now || cmd.load_saved || cmd.pop) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_now) begin
			out_ev   <= fin;
			out_last <= 1'b1;
		end else if (cmd.load_saved) begin
			out_ev   <= fin_q;
			out_last <= 1'b1;
		end else if (cmd.pop) begin
			out_ev   <= pop_ev;
			out_last <= plan_one_q;
		end
	end

	always_comb begin
		st            = '0;
		st.flush_one  = flush_one;
		st.flush_all  = flush_all;
		st.has_final  = fin_valid;
		st.held_empty = (cnt_q == '0);
		st.held_last  = (cnt_q == CNT_W'(1));
		st.plan_one   = plan_one_q;
		st.out_free   = !out_valid || out_ready;
	end

endmodule

@@ sv/csv_field_tokenizer_core.sv @@
// Top level of the CSV field tokenizer: stream ports, controller and datapath.
`timescale 1ns / 1ps

// The block takes one CSV byte or end-of-input marker per input transfer and delivers field
// bytes, field ends, record ends and errors as output transfers, one result per cycle from a
// single output register while m_tready stays high. After a byte that gives at most one
// result, the next byte is taken in the following cycle even while that result still waits
// on m_tready; if that next byte also gives a result, it is parked and the input waits until
// the output register frees. A byte that releases held trailing blanks is taken, each blank is
// shifted out of the blank hold register in turn, and then the byte itself is delivered. A
// blank that pushes the oldest held blank out of a full hold register is taken, then the oldest
// blank is shifted out. When a result cannot leave the output register, the input waits too.
// The user must write settings through cfg_wr_en while the block is idle; the block does not check.
module csv_field_tokenizer_core #(
	parameter int BLANK_HOLD = 16,
	parameter int LINE_BITS  = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // byte_value
	input  logic        s_tuser,   // kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // data_byte, quoted flag, line_number, column_number,
	                               // error_code, zero fill
	output logic [1:0]  m_tuser,   // event_res
	output logic        m_tlast
);

	csvft_pkg::status_t st;
	csvft_pkg::cmd_t    cmd;
	csvft_pkg::event_t  out_ev;

	csvft_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	csvft_dp #(
		.BLANK_HOLD (BLANK_HOLD),
		.LINE_BITS  (LINE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_kind   (s_tuser),
		.in_byte   (s_tdata),
		.cmd       (cmd),
		.st        (st),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_ev    (out_ev),
		.out_last  (m_tlast)
	);

	assign m_tdata = {4'b0000, out_ev.err, out_ev.col, out_ev.line, out_ev.quoted, out_ev.data};
	assign m_tuser = out_ev.ev;

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench of the CSV field tokenizer: directed and random byte streams.
`timescale 1ns / 1ps

module testbench;

	localparam int BLANK_HOLD = 16;
	localparam int LINE_BITS = 32;
	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_EOI = 1'b1;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_SEMI = 8'h3B;
	localparam logic [7:0] CH_TOP = 8'hFF;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [31:0] LINE_MAX = 32'hFFFF_FFFF;
	localparam logic [15:0] FIELD_MAX = 16'hFFFF;
	localparam int SETTLE_CYCLES = BLANK_HOLD + 8;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_OFF_CYCLES = 300;

	typedef enum logic [1:0] {
		PM_FIELD,
		PM_IN_QUOTES,
		PM_QUOTE_PENDING,
		PM_AFTER_QUOTE
	} parse_mode_t;

	typedef struct packed {
		logic [1:0]  ev;
		logic [7:0]  data;
		logic        quoted;
		logic [31:0] line;
		logic [15:0] col;
		logic [2:0]  err;
		logic        last;
	} token_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [1:0]  cfg_index = csvft_pkg::CFG_DELIM;
	logic [7:0]  cfg_wdata = 8'd0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'd0;
	logic        s_tuser = KIND_BYTE;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	int send_gap_pct = 0;
	int stall_pct = 0;
	logic hold_ready = 1'b0;
	int live_items = 0;
	int mismatches = 0;
	int quiet_cycles = 0;
	int step_tokens;
	token_t token_q[$];

	// Tokenizer state as the testbench tracks it.
	logic [7:0] cfg_delim = CH_COMMA;
	logic cfg_trim = 1'b1;
	logic cfg_skip = 1'b1;
	parse_mode_t pm_mode;
	logic pm_after_cr;
	logic [BLANK_HOLD-1:0] pm_held_tabs;
	int pm_held_n;
	logic [31:0] pm_phys_line;
	logic [31:0] pm_rec_line;
	logic [15:0] pm_field_idx;
	logic pm_quoted;
	logic pm_raw;
	logic pm_emitted;
	logic pm_halted;

	csv_field_tokenizer_core #(
		.BLANK_HOLD(BLANK_HOLD),
		.LINE_BITS(LINE_BITS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function void push_token(logic [1:0] ev, logic [7:0] data, logic quoted,
			logic [31:0] line, logic [15:0] col, logic [2:0] err);
		token_t t;
		t.ev = ev;
		t.data = data;
		t.quoted = quoted;
		t.line = line;
		t.col = col;
		t.err = err;
		t.last = 1'b0;
		token_q = {token_q, t};
		step_tokens++;
	endfunction

	function void emit_char(logic [7:0] c);
		push_token(csvft_pkg::EV_BYTE, c, 1'b0, pm_rec_line, 16'd0, csvft_pkg::ERR_NONE);
	endfunction

	function void emit_error(logic [2:0] code, logic [31:0] line);
		push_token(csvft_pkg::EV_ERR, 8'd0, 1'b0, line,
			(pm_field_idx == FIELD_MAX) ? FIELD_MAX : pm_field_idx + 16'd1, code);
	endfunction

	function void restart_document();
		pm_mode = PM_FIELD;
		pm_after_cr = 1'b0;
		pm_held_tabs = '0;
		pm_held_n = 0;
		pm_phys_line = 32'd1;
		pm_rec_line = 32'd1;
		pm_field_idx = 16'd0;
		pm_quoted = 1'b0;
		pm_raw = 1'b0;
		pm_emitted = 1'b0;
		pm_halted = 1'b0;
	endfunction

	function void clear_field();
		pm_held_tabs = '0;
		pm_held_n = 0;
		pm_quoted = 1'b0;
		pm_raw = 1'b0;
		pm_emitted = 1'b0;
		pm_mode = PM_FIELD;
	endfunction

	function void release_oldest_blank();
		emit_char(pm_held_tabs[0] ? csvft_pkg::CH_TAB : csvft_pkg::CH_SPACE);
		pm_held_tabs = pm_held_tabs >> 1;
		pm_held_n--;
	endfunction

	function void close_field();
		push_token(csvft_pkg::EV_FIELD, 8'd0, pm_quoted, pm_rec_line, 16'd0,
			csvft_pkg::ERR_NONE);
		clear_field();
		if (pm_field_idx != FIELD_MAX)
			pm_field_idx++;
	endfunction

	function void close_record();
		logic empty_rec;
		empty_rec = (pm_field_idx == 16'd0) && !pm_quoted && !pm_emitted;
		if (!(cfg_skip && empty_rec))
			push_token(csvft_pkg::EV_REC, 8'd0, pm_quoted, pm_rec_line, 16'd0,
				csvft_pkg::ERR_NONE);
		clear_field();
		pm_field_idx = 16'd0;
	endfunction

	function void bump_line();
		if (pm_phys_line != LINE_MAX)
			pm_phys_line++;
	endfunction

	function void take_line_break(logic [7:0] c);
		close_record();
		bump_line();
		pm_rec_line = pm_phys_line;
		pm_after_cr = (c == csvft_pkg::CH_CR);
	endfunction

	function void take_unquoted(logic [7:0] c);
		pm_raw = 1'b1;
		if ((c == csvft_pkg::CH_SPACE || c == csvft_pkg::CH_TAB) && cfg_trim) begin
			if (!pm_emitted)
				return;
			// A full hold register gives up its oldest blank as field content.
			if (pm_held_n >= BLANK_HOLD)
				release_oldest_blank();
			if (c == csvft_pkg::CH_TAB)
				pm_held_tabs[pm_held_n] = 1'b1;
			pm_held_n++;
			return;
		end
		while (pm_held_n > 0)
			release_oldest_blank();
		emit_char(c);
		pm_emitted = 1'b1;
	endfunction

	function void take_byte(logic [7:0] c);
		logic is_delim;
		logic is_nl;
		is_delim = (c == cfg_delim);
		is_nl = (c == csvft_pkg::CH_CR || c == csvft_pkg::CH_LF);
		if (pm_after_cr) begin
			pm_after_cr = 1'b0;
			if (c == csvft_pkg::CH_LF)
				return;
		end
		if (pm_mode == PM_IN_QUOTES) begin
			if (c == csvft_pkg::CH_QUOTE) begin
				pm_mode = PM_QUOTE_PENDING;
			end else if (is_nl) begin
				emit_char(csvft_pkg::CH_LF);
				bump_line();
				pm_after_cr = (c == csvft_pkg::CH_CR);
			end else begin
				emit_char(c);
			end
			return;
		end
		if (pm_mode == PM_QUOTE_PENDING) begin
			if (c == csvft_pkg::CH_QUOTE) begin
				emit_char(csvft_pkg::CH_QUOTE);
				pm_mode = PM_IN_QUOTES;
				return;
			end
			pm_mode = PM_AFTER_QUOTE;
		end
		if (pm_mode == PM_AFTER_QUOTE) begin
			if (is_delim) begin
				close_field();
			end else if (is_nl) begin
				take_line_break(c);
			end else if (c != csvft_pkg::CH_SPACE && c != csvft_pkg::CH_TAB) begin
				emit_error(csvft_pkg::ERR_AFTER_Q, pm_phys_line);
				pm_halted = 1'b1;
			end
			return;
		end
		if (is_delim) begin
			close_field();
		end else if (is_nl) begin
			take_line_break(c);
		end else if (c == csvft_pkg::CH_QUOTE) begin
			if (pm_emitted) begin
				emit_error(csvft_pkg::ERR_MISPLACE, pm_phys_line);
				pm_halted = 1'b1;
				return;
			end
			clear_field();
			pm_quoted = 1'b1;
			pm_mode = PM_IN_QUOTES;
		end else begin
			take_unquoted(c);
		end
	endfunction

	function void take_end_of_input();
		if (pm_mode == PM_IN_QUOTES)
			emit_error(csvft_pkg::ERR_EOF_Q, pm_rec_line);
		else if (pm_mode != PM_FIELD || pm_field_idx != 16'd0 || pm_raw)
			close_record();
		restart_document();
	endfunction

	function void predict_transfer(logic kind, logic [7:0] c);
		token_t t;
		step_tokens = 0;
		if (pm_halted) begin
			if (kind == KIND_EOI)
				restart_document();
		end else if (cfg_delim == csvft_pkg::CH_NUL || cfg_delim == csvft_pkg::CH_QUOTE
				|| cfg_delim == csvft_pkg::CH_CR || cfg_delim == csvft_pkg::CH_LF) begin
			push_token(csvft_pkg::EV_ERR, 8'd0, 1'b0, 32'd0, 16'd0, csvft_pkg::ERR_DELIM);
			if (kind == KIND_EOI)
				restart_document();
			else
				pm_halted = 1'b1;
		end else if (kind == KIND_EOI) begin
			take_end_of_input();
		end else begin
			take_byte(c);
		end
		if (step_tokens > 0) begin
			t = token_q.pop_back();
			t.last = 1'b1;
			token_q = {token_q, t};
		end
	endfunction

	always @(posedge clk) begin
		m_tready <= !hold_ready && ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin : check_results
		token_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (token_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: event %0d tdata %h last %b",
						m_tuser, m_tdata, m_tlast);
			end else begin
				want = token_q.pop_front();
				if (m_tuser !== want.ev || m_tlast !== want.last
						|| m_tdata[59:0] !== {want.err, want.col, want.line,
						want.quoted, want.data}) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch: expected ev %0d data %h q %b line %0d col %0d err %0d last %b",
							want.ev, want.data, want.quoted, want.line, want.col,
							want.err, want.last);
						$display("          actual   ev %0d data %h q %b line %0d col %0d err %0d last %b",
							m_tuser, m_tdata[7:0], m_tdata[8], m_tdata[40:9],
							m_tdata[56:41], m_tdata[59:57], m_tlast);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	task automatic send_item(input logic kind, input logic [7:0] value);
		while ($urandom_range(99) < send_gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= value;
		do
			@(posedge clk);
		while (!s_tready);
		if (!pm_halted)
			live_items++;
		predict_transfer(kind, value);
	endtask

	task automatic send_text(input string text);
		for (int i = 0; i < text.len(); i++)
			send_item(KIND_BYTE, text[i]);
	endtask

	task automatic send_blanks(input int count);
		repeat (count)
			send_item(KIND_BYTE, $urandom_range(1) ? csvft_pkg::CH_TAB : csvft_pkg::CH_SPACE);
	endtask

	task automatic send_end_of_input();
		send_item(KIND_EOI, 8'($urandom_range(0, 255)));
	endtask

	task automatic send_line_break();
		case ($urandom_range(0, 2))
			0: send_text("\r\n");
			1: send_item(KIND_BYTE, csvft_pkg::CH_LF);
			default: send_item(KIND_BYTE, csvft_pkg::CH_CR);
		endcase
	endtask

	// Waits for the block to drain; bytes that only feed the blank hold give no result.
	task automatic settle();
		s_tvalid <= 1'b0;
		while (token_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	task automatic write_setting(input logic [1:0] index, input logic [7:0] value);
		cfg_wr_en <= 1'b1;
		cfg_index <= index;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (index)
			csvft_pkg::CFG_DELIM: cfg_delim = value;
			csvft_pkg::CFG_TRIM: cfg_trim = value[0];
			csvft_pkg::CFG_SKIP: cfg_skip = value[0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic apply_settings(input logic [7:0] delim, input logic trim, input logic skip);
		write_setting(csvft_pkg::CFG_DELIM, delim);
		write_setting(csvft_pkg::CFG_TRIM, {7'd0, trim});
		write_setting(csvft_pkg::CFG_SKIP, {7'd0, skip});
	endtask

	function automatic logic [7:0] pick_plain();
		logic [7:0] c;
		do begin
			if ($urandom_range(1))
				c = CH_LOWER_A + 8'($urandom_range(0, 25));
			else
				c = 8'($urandom_range(0, 255));
		end while (c == csvft_pkg::CH_QUOTE || c == csvft_pkg::CH_CR || c == csvft_pkg::CH_LF
			|| c == csvft_pkg::CH_SPACE || c == csvft_pkg::CH_TAB || c == cfg_delim);
		return c;
	endfunction

	task automatic send_field();
		int n;
		if ($urandom_range(0, 9) < 4) begin
			if ($urandom_range(0, 4) == 0)
				send_blanks(1);
			send_item(KIND_BYTE, csvft_pkg::CH_QUOTE);
			n = $urandom_range(0, 4);
			repeat (n) begin
				case ($urandom_range(0, 7))
					0: send_text("\"\"");
					1: send_item(KIND_BYTE,
						$urandom_range(1) ? csvft_pkg::CH_CR : csvft_pkg::CH_LF);
					2: send_text("\r\n");
					3: send_item(KIND_BYTE, cfg_delim);
					4: send_blanks(1);
					default: send_item(KIND_BYTE, pick_plain());
				endcase
			end
			send_item(KIND_BYTE, csvft_pkg::CH_QUOTE);
			send_blanks($urandom_range(0, 2));
			if ($urandom_range(0, 14) == 0)
				send_item(KIND_BYTE, pick_plain());
		end else begin
			send_blanks($urandom_range(0, 2));
			n = $urandom_range(0, 4);
			repeat (n) begin
				if ($urandom_range(0, 5) == 0)
					send_blanks(1);
				else
					send_item(KIND_BYTE, pick_plain());
			end
			if ($urandom_range(0, 19) == 0)
				send_item(KIND_BYTE, csvft_pkg::CH_QUOTE);
			if ($urandom_range(0, 7) == 0)
				send_blanks($urandom_range(15, 20));
			else
				send_blanks($urandom_range(0, 2));
		end
	endtask

	task automatic send_records(input int goal);
		int nf;
		while (live_items < goal) begin
			case ($urandom_range(0, 19))
				0: send_item(KIND_BYTE, 8'($urandom_range(0, 255)));
				1: send_end_of_input();
				2: send_line_break();
				default: begin
					nf = $urandom_range(1, 3);
					for (int f = 0; f < nf; f++) begin
						if (f > 0)
							send_item(KIND_BYTE, cfg_delim);
						send_field();
					end
					if ($urandom_range(0, 9) < 8)
						send_line_break();
					else
						send_end_of_input();
				end
			endcase
		end
		send_end_of_input();
	endtask

	task automatic test_fields_and_quotes();
		send_text(" a b ,\"x\"\"y\" ,\t\r\n");
		send_item(KIND_BYTE, csvft_pkg::CH_NUL);
		send_item(KIND_BYTE, CH_TOP);
		send_end_of_input();
		send_text("\"p\r\nq\rr\ns\"");
		send_end_of_input();
		settle();
	endtask

	task automatic test_blank_overflow();
		send_text("a");
		send_blanks(18);
		send_text("b\nc");
		send_blanks(17);
		send_text("\n");
		send_end_of_input();
		settle();
	endtask

	task automatic test_trim_switch();
		send_text("d \t");
		settle();
		write_setting(csvft_pkg::CFG_TRIM, 8'd0);
		send_text("e");
		settle();
		write_setting(csvft_pkg::CFG_TRIM, 8'd1);
		send_text("  ");
		settle();
		write_setting(csvft_pkg::CFG_TRIM, 8'd0);
		send_text(", f \n");
		send_end_of_input();
		settle();
		write_setting(csvft_pkg::CFG_TRIM, 8'd1);
	endtask

	task automatic test_blank_records();
		write_setting(csvft_pkg::CFG_SKIP, 8'd0);
		send_text("\n\"\"\n\r\n");
		send_end_of_input();
		settle();
		write_setting(csvft_pkg::CFG_SKIP, 8'd1);
		send_text("\n \n");
		send_end_of_input();
		settle();
	endtask

	task automatic test_parse_errors();
		send_text("ab\"x");
		send_end_of_input();
		send_text("\"a\"x");
		send_end_of_input();
		send_text("\"ab");
		send_end_of_input();
		send_end_of_input();
		settle();
	endtask

	task automatic test_delimiter_choice();
		logic [7:0] bad_delims [4];
		bad_delims = '{csvft_pkg::CH_NUL, csvft_pkg::CH_QUOTE, csvft_pkg::CH_CR,
			csvft_pkg::CH_LF};
		foreach (bad_delims[i]) begin
			write_setting(csvft_pkg::CFG_DELIM, bad_delims[i]);
			send_text("ab");
			send_end_of_input();
			send_end_of_input();
			settle();
		end
		write_setting(csvft_pkg::CFG_DELIM, CH_TOP);
		send_text("a");
		send_item(KIND_BYTE, CH_TOP);
		send_text("b\n");
		settle();
		write_setting(csvft_pkg::CFG_DELIM, csvft_pkg::CH_SPACE);
		send_text("a b\n");
		send_end_of_input();
		settle();
		write_setting(csvft_pkg::CFG_DELIM, CH_COMMA);
	endtask

	// The receiver holds off while records keep coming, so the input side backs up.
	task automatic test_input_stall();
		fork
			begin
				hold_ready <= 1'b1;
				repeat (HOLD_OFF_CYCLES)
					@(posedge clk);
				hold_ready <= 1'b0;
			end
		join_none
		send_records(live_items + 5);
		settle();
	endtask

	task automatic test_random_traffic(input int gap_pct, input int busy_pct,
			input logic [7:0] delim, input logic trim, input logic skip, input int count);
		apply_settings(delim, trim, skip);
		send_gap_pct = gap_pct;
		stall_pct = busy_pct;
		send_records(live_items + count);
		settle();
	endtask

	initial begin
		restart_document();
		repeat (12)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_fields_and_quotes();
		test_blank_overflow();
		test_trim_switch();
		test_blank_records();
		test_parse_errors();
		test_delimiter_choice();
		test_input_stall();
		test_random_traffic(0, 0, CH_COMMA, 1'b1, 1'b1, 5);
		test_random_traffic(51, 0, CH_SEMI, 1'b0, 1'b0, 5);
		test_random_traffic(0, 51, CH_TOP, 1'b1, 1'b0, 5);
		test_random_traffic(19, 19, csvft_pkg::CH_TAB, 1'b1, 1'b1, 5);
		if (mismatches == 0 && token_q.size() == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
